FILE: rtl/crx_pkg.sv
// Shared types and constants for the CAN receive id slot table.
package crx_pkg;

  localparam int ID_W       = 11;
  localparam int DATA_W     = 64;
  localparam int LEN_W      = 4;
  localparam int SINK_W     = 2;
  localparam int SLOT_FLD_W = 4;   // width of the reported slot index
  localparam int SLOT_IDX_W = 6;   // internal index, covers up to 64 slots
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int HALF_W     = DATA_W / 2;

  localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(8);
  localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(4);

  localparam logic [ID_W-1:0] RST_ID_SHORT = 11'h212;
  localparam logic [ID_W-1:0] RST_ID_FULL  = 11'h0FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIVER_EN  = 2'd0,
    CFG_SPECIAL_EN  = 2'd1,
    CFG_ID_SHORT    = 2'd2,
    CFG_ID_FULL     = 2'd3
  } cfg_reg_t;

  typedef enum logic [SINK_W-1:0] {
    SINK_USER  = 2'd0,
    SINK_SHORT = 2'd1,
    SINK_FULL  = 2'd2
  } sink_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Search token passed from cell to cell, one hop per cycle.
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } tok_t;

  // Write broadcast from the controller to every cell.
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  id_en;
    logic [ID_W-1:0]       id;
    logic [DATA_W-1:0]     data;
    logic                  low_only;
    logic [LEN_W-1:0]      len;
  } wr_t;

endpackage

FILE: rtl/crx_if.sv
// Handshake channel interfaces for frame input and slot result output.
interface crx_in_if;
  import crx_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   frame_id;
  logic [DATA_W-1:0] frame_data;
  modport source (output valid, output frame_id, output frame_data, input ready);
  modport sink   (input valid, input frame_id, input frame_data, output ready);
endinterface

interface crx_out_if;
  import crx_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SLOT_FLD_W-1:0] slot_index;
  logic [ID_W-1:0]       entry_id;
  logic [DATA_W-1:0]     entry_data;
  logic [LEN_W-1:0]      entry_length;
  logic [SINK_W-1:0]     entry_sink;
  logic                  newly_allocated;
  logic                  full_overwrite;
  modport source (output valid, output slot_index, output entry_id, output entry_data,
                  output entry_length, output entry_sink, output newly_allocated,
                  output full_overwrite, input ready);
  modport sink   (input valid, input slot_index, input entry_id, input entry_data,
                  input entry_length, input entry_sink, input newly_allocated,
                  input full_overwrite, output ready);
endinterface

FILE: rtl/crx_slot_cell.sv
// One table slot: holds id, payload and length, and advances the search token.
module crx_slot_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [crx_pkg::ID_W-1:0]  key,
  input  crx_pkg::tok_t             tok_in,
  input  crx_pkg::wr_t              wr,
  output crx_pkg::tok_t             tok_out,
  output logic [crx_pkg::ID_W-1:0]  id_o,
  output logic [crx_pkg::DATA_W-1:0] data_o
);
  import crx_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_IDX);

  logic [ID_W-1:0]   id_r,   id_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [LEN_W-1:0]  len_r,  len_nxt;
  tok_t              tok_r,  tok_nxt;
  logic              sel;

  assign sel = wr.en && (wr.idx == MY_IDX);

  always_comb begin
    id_nxt   = id_r;
    data_nxt = data_r;
    len_nxt  = len_r;
    if (sel) begin
      if (wr.id_en) begin
        id_nxt = wr.id;
      end
      if (wr.low_only) begin
        data_nxt = {data_r[DATA_W-1:HALF_W], wr.data[HALF_W-1:0]};
      end else begin
        data_nxt = wr.data;
      end
      len_nxt = wr.len;
    end
  end

  // first match and first free slot win; later cells leave them alone
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.hit && (id_r == key)) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = MY_IDX;
    end
    if (tok_in.valid && !tok_in.free && (id_r == '0)) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r   <= '0;
      data_r <= '0;
      len_r  <= '0;
      tok_r  <= '0;
    end else begin
      id_r   <= id_nxt;
      data_r <= data_nxt;
      len_r  <= len_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign id_o    = id_r;
  assign data_o  = data_r;

endmodule

FILE: rtl/can_rx_id_slot_table.sv
// Top level of the CAN receive id slot table: control, config and cell row.
//
// Files received standard CAN frames into a table of SLOT_COUNT slots keyed
// by 11-bit id. in_ch carries one frame per beat (frame_id, frame_data).
// out_ch carries at most one result beat per frame: the slot written, its
// id, data and length after the write, the sink, and new/overwrite flags.
// Ordinary frames give a result only with deliver_enable set; the two
// special ids (when special_route_enable is set) always give one, sink 1
// or 2, and update slot 0 without touching its id.
// cfg_we/cfg_index/cfg_wdata write the four registers, one per cycle.
//
// Timing: after an input beat a search token walks the row of slot cells,
// one cell per cycle, collecting the first matching and first free slot.
// The write and the result register load follow at the same edge, once
// the token has left the last cell and the FSM is in its commit state;
// in_ch.ready returns then, so a new frame is taken only after the last
// one is written. The result beat is valid the cycle after the write.
// Reset (synchronous rst_n) clears all slots to free/zero and loads the
// register defaults. If out_ch stalls, the result is held and the next
// frame is still taken and searched; only its write, when it gives a
// result, waits for the output register to empty.
module can_rx_id_slot_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  crx_in_if.sink                          in_ch,
  crx_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [crx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import crx_pkg::*;

  // config registers
  logic            deliver_en_r, special_en_r;
  logic [ID_W-1:0] id_short_r, id_full_r;

  // frame held for the search
  logic [ID_W-1:0]   key_r;
  logic [DATA_W-1:0] fdata_r;

  state_t state_r, state_nxt;
  tok_t   tok0_r, tok0_nxt;
  tok_t   tail_r;
  tok_t   tok [SLOT_COUNT+1];
  wr_t    wr;

  logic [ID_W-1:0]   cell_id   [SLOT_COUNT];
  logic [DATA_W-1:0] cell_data [SLOT_COUNT];

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [SLOT_FLD_W-1:0] o_slot_r;
  logic [ID_W-1:0]       o_id_r;
  logic [DATA_W-1:0]     o_data_r;
  logic [LEN_W-1:0]      o_len_r;
  sink_t                 o_sink_r;
  logic                  o_new_r, o_over_r;

  logic                  accept, sp_short, sp_full, emit, commit, out_free;
  logic [SLOT_IDX_W-1:0] slot_sel;
  logic [ID_W-1:0]       res_id;
  logic [DATA_W-1:0]     res_data;
  logic [LEN_W-1:0]      res_len;
  sink_t                 res_sink;

  assign accept = in_ch.valid && in_ch.ready;

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deliver_en_r <= 1'b0;
      special_en_r <= 1'b0;
      id_short_r   <= RST_ID_SHORT;
      id_full_r    <= RST_ID_FULL;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DELIVER_EN: deliver_en_r <= cfg_wdata[0];
        CFG_SPECIAL_EN: special_en_r <= cfg_wdata[0];
        CFG_ID_SHORT:   id_short_r   <= cfg_wdata[ID_W-1:0];
        CFG_ID_FULL:    id_full_r    <= cfg_wdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- cell row ----------------
  assign tok[0] = tok0_r;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    crx_slot_cell #(.CELL_IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .key     (key_r),
      .tok_in  (tok[g]),
      .wr      (wr),
      .tok_out (tok[g+1]),
      .id_o    (cell_id[g]),
      .data_o  (cell_data[g])
    );
  end

  // ---------------- decision ----------------
  // short special wins when both special ids are equal
  assign sp_short = special_en_r && (key_r == id_short_r);
  assign sp_full  = special_en_r && (key_r == id_full_r) && !sp_short;
  assign emit     = sp_short || sp_full || deliver_en_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = (state_r == ST_COMMIT) && (!emit || out_free);

  always_comb begin
    slot_sel = '0;
    if (!sp_short && !sp_full) begin
      if (tail_r.hit) begin
        slot_sel = tail_r.hit_idx;
      end else if (tail_r.free) begin
        slot_sel = tail_r.free_idx;
      end
    end
  end

  always_comb begin
    res_id   = key_r;
    res_data = fdata_r;
    res_len  = LEN_FULL;
    res_sink = SINK_USER;
    if (sp_short) begin
      res_id   = cell_id[0];
      res_data = {cell_data[0][DATA_W-1:HALF_W], fdata_r[HALF_W-1:0]};
      res_len  = LEN_SHORT;
      res_sink = SINK_SHORT;
    end else if (sp_full) begin
      res_id   = cell_id[0];
      res_sink = SINK_FULL;
    end
  end

  always_comb begin
    wr          = '0;
    wr.en       = commit;
    wr.idx      = slot_sel;
    wr.id_en    = !sp_short && !sp_full;
    wr.id       = key_r;
    wr.data     = fdata_r;
    wr.low_only = sp_short;
    wr.len      = res_len;
  end

  // ---------------- control FSM ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (tok[SLOT_COUNT].valid) state_nxt = ST_COMMIT;
      ST_COMMIT: if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tok0_nxt       = '0;
    tok0_nxt.valid = accept;
    in_ch.ready    = (state_r == ST_IDLE);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tok0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok0_r      <= tok0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= in_ch.frame_id;
      fdata_r <= in_ch.frame_data;
    end
    if ((state_r == ST_SCAN) && tok[SLOT_COUNT].valid) begin
      tail_r <= tok[SLOT_COUNT];
    end
    if (commit && emit) begin
      o_slot_r <= slot_sel[SLOT_FLD_W-1:0];
      o_id_r   <= res_id;
      o_data_r <= res_data;
      o_len_r  <= res_len;
      o_sink_r <= res_sink;
      o_new_r  <= !sp_short && !sp_full && !tail_r.hit && tail_r.free;
      o_over_r <= !sp_short && !sp_full && !tail_r.hit && !tail_r.free;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.slot_index      = o_slot_r;
  assign out_ch.entry_id        = o_id_r;
  assign out_ch.entry_data      = o_data_r;
  assign out_ch.entry_length    = o_len_r;
  assign out_ch.entry_sink      = o_sink_r;
  assign out_ch.newly_allocated = o_new_r;
  assign out_ch.full_overwrite  = o_over_r;

endmodule
